/* sv/mrct_pkg.sv */
// Shared types, codes and constants of the memory region classifier table.
`timescale 1ns / 1ps
package mrct_pkg;

  localparam int MRCT_TABLE_ENTRIES = 64;

  localparam int OP_W   = 2;
  localparam int CTX_W  = 8;
  localparam int CLS_W  = 2;
  localparam int ADDR_W = 64;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

  // Region classes and the lookup miss code
  localparam logic [CLS_W-1:0] CLS_SHARED = 2'd0;
  localparam logic [CLS_W-1:0] CLS_DEVICE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_HOST   = 2'd2;
  localparam logic [CLS_W-1:0] LOC_NONE   = 2'd3;
  localparam int               NUM_CLS    = 3;

  // One table row
  typedef struct packed {
    logic              vld;
    logic [CTX_W-1:0]  ctx;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] lim;
  } row_t;

  // Controller to datapath
  typedef struct packed {
    logic cnt_clr;
    logic cnt_inc;
    logic mem_clr;
    logic mem_rd;
    logic latch;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;
    logic out_free;
  } sts_t;

endpackage

/* sv/mrct_in_if.sv */
// Input channel: valid/ready handshake with one request transaction.
`timescale 1ns / 1ps
interface mrct_in_if;
  import mrct_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [CTX_W-1:0]  context_req;
  logic [CLS_W-1:0]  region_class;
  logic [ADDR_W-1:0] address;
  logic [ADDR_W-1:0] length;

  modport source (output valid, op, context_req, region_class, address, length,
                  input ready);
  modport sink   (input valid, op, context_req, region_class, address, length,
                  output ready);
endinterface

/* sv/mrct_out_if.sv */
// Result channel: valid/ready handshake with one result transaction.
`timescale 1ns / 1ps
interface mrct_out_if;
  import mrct_pkg::*;

  logic              valid;
  logic              ready;
  logic [CLS_W-1:0]  location;
  logic [ADDR_W-1:0] removed_size;
  logic              overflow;

  modport source (output valid, location, removed_size, overflow, input ready);
  modport sink   (input valid, location, removed_size, overflow, output ready);
endinterface

/* sv/mrct_datapath.sv */
// Datapath: table memory, scan counter, match trackers and result register.
`timescale 1ns / 1ps
module mrct_datapath #(
  parameter int TABLE_ENTRIES = mrct_pkg::MRCT_TABLE_ENTRIES
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mrct_pkg::cmd_t             cmd,
  output mrct_pkg::sts_t             sts,
  input  logic [mrct_pkg::OP_W-1:0]   in_op,
  input  logic [mrct_pkg::CTX_W-1:0]  in_context_req,
  input  logic [mrct_pkg::CLS_W-1:0]  in_region_class,
  input  logic [mrct_pkg::ADDR_W-1:0] in_address,
  input  logic [mrct_pkg::ADDR_W-1:0] in_length,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mrct_pkg::CLS_W-1:0]  out_location,
  output logic [mrct_pkg::ADDR_W-1:0] out_removed_size,
  output logic                       out_overflow
);
  import mrct_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  row_t mem [TABLE_ENTRIES];

  logic [IW-1:0]     cnt_r;
  logic [IW-1:0]     rd_idx_r;
  logic              rd_vld_r;
  row_t              q_r;

  // latched request
  logic [OP_W-1:0]   op_r;
  logic [CTX_W-1:0]  ctx_r;
  logic [CLS_W-1:0]  cls_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W-1:0] len_r;

  // insert trackers
  logic              ins_hit_r;
  logic [IW-1:0]     ins_idx_r;
  logic              free_fnd_r;
  logic [IW-1:0]     free_idx_r;
  // remove tracker
  logic              rm_fnd_r;
  logic [CLS_W-1:0]  rm_cls_r;
  logic [IW-1:0]     rm_idx_r;
  logic [ADDR_W-1:0] rm_size_r;
  // lookup trackers, one per class
  logic [NUM_CLS-1:0] lk_fnd_r;
  logic [ADDR_W-1:0]  lk_base_r [NUM_CLS];
  logic [ADDR_W-1:0]  lk_lim_r  [NUM_CLS];

  // result register
  logic              out_valid_r;
  logic [CLS_W-1:0]  loc_r;
  logic [ADDR_W-1:0] rsize_r;
  logic              ovf_r;

  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  row_t              wr_row;
  logic [CLS_W-1:0]  loc_nxt;
  logic [ADDR_W-1:0] rsize_nxt;
  logic              ovf_nxt;
  logic              base_eq;

  assign sts.cnt_last = (cnt_r == LAST_IDX);
  assign sts.out_free = !out_valid_r || out_ready;

  assign base_eq = q_r.vld && (q_r.ctx == ctx_r) && (q_r.base == addr_r);

  // memory write source: clearing pass or commit
  always_comb begin
    wr_en  = 1'b0;
    wr_idx = cnt_r;
    wr_row = '0;
    if (cmd.mem_clr) begin
      wr_en = 1'b1;
    end else if (cmd.commit) begin
      unique case (op_r)
        OP_INSERT: begin
          wr_row.vld  = 1'b1;
          wr_row.ctx  = ctx_r;
          wr_row.cls  = cls_r;
          wr_row.base = addr_r;
          wr_row.lim  = addr_r + len_r;
          if (cls_r != LOC_NONE) begin
            if (ins_hit_r) begin
              wr_en  = 1'b1;
              wr_idx = ins_idx_r;
            end else if (free_fnd_r) begin
              wr_en  = 1'b1;
              wr_idx = free_idx_r;
            end
          end
        end
        OP_REMOVE: begin
          wr_en  = rm_fnd_r;
          wr_idx = rm_idx_r;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  // result; lowest class that covers the address wins
  always_comb begin
    loc_nxt = LOC_NONE;
    if (op_r == OP_LOOKUP) begin
      for (int c = NUM_CLS - 1; c >= 0; c--) begin
        if (lk_fnd_r[c] && (addr_r < lk_lim_r[c])) begin
          loc_nxt = CLS_W'(c);
        end
      end
    end
    rsize_nxt = (op_r == OP_REMOVE && rm_fnd_r) ? rm_size_r : '0;
    ovf_nxt   = (op_r == OP_INSERT) && (cls_r != LOC_NONE) && !ins_hit_r && !free_fnd_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
    if (cmd.mem_rd) begin
      q_r <= mem[cnt_r];
    end
  end

  // scan counter and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
      rd_vld_r <= cmd.mem_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (cmd.latch) begin
      op_r   <= in_op;
      ctx_r  <= in_context_req;
      cls_r  <= in_region_class;
      addr_r <= in_address;
      len_r  <= in_length;
    end
  end

  // trackers: updated with each row that comes back from the memory
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_hit_r  <= 1'b0;
      free_fnd_r <= 1'b0;
      rm_fnd_r   <= 1'b0;
      lk_fnd_r   <= '0;
    end else if (cmd.latch) begin
      ins_hit_r  <= 1'b0;
      free_fnd_r <= 1'b0;
      rm_fnd_r   <= 1'b0;
      lk_fnd_r   <= '0;
    end else if (rd_vld_r) begin
      if (base_eq && (q_r.cls == cls_r) && !ins_hit_r) begin
        ins_hit_r <= 1'b1;
        ins_idx_r <= rd_idx_r;
      end
      if (!q_r.vld && !free_fnd_r) begin
        free_fnd_r <= 1'b1;
        free_idx_r <= rd_idx_r;
      end
      if (base_eq && (q_r.cls != LOC_NONE) && (!rm_fnd_r || (q_r.cls < rm_cls_r))) begin
        rm_fnd_r  <= 1'b1;
        rm_cls_r  <= q_r.cls;
        rm_idx_r  <= rd_idx_r;
        rm_size_r <= q_r.lim - q_r.base;
      end
      for (int c = 0; c < NUM_CLS; c++) begin
        if (q_r.vld && (q_r.ctx == ctx_r) && (q_r.cls == CLS_W'(c)) &&
            (q_r.base <= addr_r) && (!lk_fnd_r[c] || (q_r.base > lk_base_r[c]))) begin
          lk_fnd_r[c]  <= 1'b1;
          lk_base_r[c] <= q_r.base;
          lk_lim_r[c]  <= q_r.lim;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      loc_r   <= loc_nxt;
      rsize_r <= rsize_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_location     = loc_r;
  assign out_removed_size = rsize_r;
  assign out_overflow     = ovf_r;

endmodule

/* sv/mrct_ctrl.sv */
// Controller: clearing pass after reset, then accept / scan / commit sequence.
`timescale 1ns / 1ps
module mrct_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  mrct_pkg::sts_t sts,
  output mrct_pkg::cmd_t cmd
);
  import mrct_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.mem_clr = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch   = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.mem_rd = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_TAIL;
        end else begin
          cmd.cnt_inc = 1'b1;
        end
      end
      S_TAIL: begin
        // last row comes back from the memory here
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/memory_region_classifier_table_unit.sv */
// Top level: memory region classifier table (controller plus datapath).
// Every request scans the whole table, one row per cycle through the single read port
//   of the table RAM; a new input transaction is taken only after the previous result
//   has been committed to the output register.
// Reset: synchronous, active low; afterwards a clearing pass marks every row invalid,
//   and no input transaction is taken until it ends.
`timescale 1ns / 1ps
module memory_region_classifier_table_unit #(
  parameter int TABLE_ENTRIES = mrct_pkg::MRCT_TABLE_ENTRIES
) (
  input  logic       clk,
  input  logic       rst_n,
  mrct_in_if.sink    in_txn,
  mrct_out_if.source out_txn
);
  import mrct_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing: clear, idle, scan, tail (read latency), done (commit).
  // The result sits in an output register, so a new transaction is taken
  // while the previous result still waits for the sink.
  mrct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_txn.valid),
    .in_ready (in_txn.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Table RAM, per-row match logic, trackers and the result register.
  // Insert: first exact match (context, class, base) else lowest free row.
  // Remove: exact base in the lowest class, first row within that class.
  // Lookup: per class the greatest base not above the address, then end check.
  mrct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_txn.op),
    .in_context_req   (in_txn.context_req),
    .in_region_class  (in_txn.region_class),
    .in_address       (in_txn.address),
    .in_length        (in_txn.length),
    .out_valid        (out_txn.valid),
    .out_ready        (out_txn.ready),
    .out_location     (out_txn.location),
    .out_removed_size (out_txn.removed_size),
    .out_overflow     (out_txn.overflow)
  );

endmodule

/* bench/memory_region_classifier_table_unit_tb.sv */
// Self-checking bench for the memory region classifier table: shadow table plus scoreboard.
`timescale 1ns / 1ps
module memory_region_classifier_table_unit_tb;
  import mrct_pkg::*;

  // Codes the package leaves unnamed; both must be harmless to the table.
  localparam logic [OP_W-1:0]  OP_NOP    = 2'd3;
  localparam logic [CLS_W-1:0] CLS_BOGUS = 2'd3;

  localparam int RANDOM_ITEMS  = 1150;
  localparam int CALM_TAIL     = 150;    // last transactions run with no idling
  localparam int LONG_HOLD     = 600;    // receiver hold-off, in cycles
  localparam int STALL_LIMIT   = 4000;   // watchdog: cycles without any transaction
  localparam int SETTLE_CYCLES = 3 * (MRCT_TABLE_ENTRIES + 3);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CTX_W-1:0]  ctx;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] len;
  } region_req_t;

  typedef struct packed {
    logic [CLS_W-1:0]  location;
    logic [ADDR_W-1:0] removed_size;
    logic              overflow;
  } region_resp_t;

  // wait_drain: hold the request back until every earlier result has come out
  typedef struct {
    region_req_t req;
    bit          wait_drain;
  } pending_req_t;

  // Ranges the generator believes are live, used to aim removes and lookups
  typedef struct {
    logic [CTX_W-1:0]  ctx;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] base;
  } live_range_t;

  logic clk = 1'b0;
  logic rst_n;

  mrct_in_if  in_bus ();
  mrct_out_if out_bus ();

  memory_region_classifier_table_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_txn (in_bus),
    .out_txn(out_bus)
  );

  always #1 clk = ~clk;

  // Shadow copy of the table; lim holds the (possibly wrapped) range end
  row_t         shadow [MRCT_TABLE_ENTRIES];
  pending_req_t pending [$];
  region_resp_t expected_q [$];

  int planned_items;
  int mismatches;

  // ---------------------------------------------------------------------------
  // Shadow table model
  // ---------------------------------------------------------------------------

  // Valid row with this exact context, class and base, or -1
  function automatic int find_row(logic [CTX_W-1:0] ctx, logic [CLS_W-1:0] cls,
                                  logic [ADDR_W-1:0] base);
    int i;
    for (i = 0; i < MRCT_TABLE_ENTRIES; i++)
      if (shadow[i].vld && shadow[i].ctx == ctx && shadow[i].cls == cls &&
          shadow[i].base == base)
        return i;
    return -1;
  endfunction

  // Lowest-numbered invalid row, or -1 when the table is full
  function automatic int free_row();
    int i;
    for (i = 0; i < MRCT_TABLE_ENTRIES; i++)
      if (!shadow[i].vld)
        return i;
    return -1;
  endfunction

  // Closest range at or below addr within one class decides; plain unsigned
  // compare against its end, so a wrapped range never covers anything.
  function automatic bit class_covers(logic [CTX_W-1:0] ctx, logic [CLS_W-1:0] cls,
                                      logic [ADDR_W-1:0] addr);
    int i;
    int best;
    best = -1;
    for (i = 0; i < MRCT_TABLE_ENTRIES; i++) begin
      if (!shadow[i].vld || shadow[i].ctx != ctx || shadow[i].cls != cls ||
          shadow[i].base > addr)
        continue;
      if (best < 0 || shadow[i].base > shadow[best].base)
        best = i;
    end
    if (best < 0)
      return 1'b0;
    return addr < shadow[best].lim;
  endfunction

  // Updates the shadow table and returns the result the request must produce
  function automatic region_resp_t apply_region_op(region_req_t r);
    region_resp_t res;
    int slot;
    int c;
    res.location     = LOC_NONE;
    res.removed_size = '0;
    res.overflow     = 1'b0;
    case (r.op)
      OP_INSERT: begin
        if (r.cls != CLS_BOGUS) begin
          slot = find_row(r.ctx, r.cls, r.addr);
          if (slot < 0) begin
            slot = free_row();
            if (slot >= 0) begin
              shadow[slot].vld  = 1'b1;
              shadow[slot].ctx  = r.ctx;
              shadow[slot].cls  = r.cls;
              shadow[slot].base = r.addr;
            end
          end
          if (slot < 0)
            res.overflow = 1'b1;
          else
            shadow[slot].lim = r.addr + r.len;
        end
      end
      OP_REMOVE: begin
        for (c = CLS_SHARED; c <= CLS_HOST; c++) begin
          slot = find_row(r.ctx, CLS_W'(c), r.addr);
          if (slot >= 0) begin
            res.removed_size = shadow[slot].lim - shadow[slot].base;
            shadow[slot].vld = 1'b0;
            break;
          end
        end
      end
      OP_LOOKUP: begin
        if (class_covers(r.ctx, CLS_SHARED, r.addr))
          res.location = CLS_SHARED;
        else if (class_covers(r.ctx, CLS_DEVICE, r.addr))
          res.location = CLS_DEVICE;
        else if (class_covers(r.ctx, CLS_HOST, r.addr))
          res.location = CLS_HOST;
      end
      default: ;  // OP_NOP leaves the table alone
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void queue_req(logic [OP_W-1:0] op, logic [CTX_W-1:0] ctx,
                                    logic [CLS_W-1:0] cls, logic [ADDR_W-1:0] addr,
                                    logic [ADDR_W-1:0] len);
    pending_req_t p;
    p.req        = '{op, ctx, cls, addr, len};
    p.wait_drain = 1'b0;
    pending.push_back(p);
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly short ranges so they overlap; some empty, some full-width (often wrapping)
  function automatic logic [ADDR_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return '0;
    if (roll <= 2)
      return rand64();
    return ADDR_W'($urandom_range(1, 'h2000));
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents pending requests, random gaps while valid is low
  // ---------------------------------------------------------------------------
  int drv_sent;
  int drv_results;
  int drv_gap;

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_bus.valid        <= 1'b0;
      in_bus.op           <= OP_NOP;
      in_bus.context_req  <= '0;
      in_bus.region_class <= CLS_SHARED;
      in_bus.address      <= '0;
      in_bus.length       <= '0;
      drv_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        drv_results++;
      if (in_bus.valid && in_bus.ready) begin
        void'(pending.pop_front());
        drv_sent++;
      end
      // valid only moves when no transaction is offered or the offered one is taken
      if (!in_bus.valid || in_bus.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (pending[0].wait_drain && drv_results != drv_sent) begin
          in_bus.valid <= 1'b0;
        end else if (drv_sent < planned_items - CALM_TAIL && (drv_sent / 90) % 3 != 2 &&
                     $urandom_range(0, 2) == 0) begin
          drv_gap = $urandom_range(1, 17) - 1;
          in_bus.valid <= 1'b0;
        end else begin
          in_bus.valid        <= 1'b1;
          in_bus.op           <= pending[0].req.op;
          in_bus.context_req  <= pending[0].req.ctx;
          in_bus.region_class <= pending[0].req.cls;
          in_bus.address      <= pending[0].req.addr;
          in_bus.length       <= pending[0].req.len;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off to back the block up
  // ---------------------------------------------------------------------------
  int rx_count;
  int rx_stall;
  bit rx_held;

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready)
        rx_count++;
      if (!rx_held && rx_count >= 150) begin
        rx_held  = 1'b1;
        rx_stall = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_bus.ready <= 1'b0;
      end else if (rx_count < planned_items - CALM_TAIL && (rx_count / 80) % 3 != 1 &&
                   $urandom_range(0, 7) == 0) begin
        rx_stall = $urandom_range(1, 17) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on each request transaction, checks each result transaction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    region_req_t  seen;
    region_resp_t want;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        seen = '{in_bus.op, in_bus.context_req, in_bus.region_class,
                 in_bus.address, in_bus.length};
        expected_q.push_back(apply_region_op(seen));
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display({"%0t: unexpected result: expected none, ",
                    "got location %0d removed_size 0x%h overflow %0b"},
                   $time, out_bus.location, out_bus.removed_size, out_bus.overflow);
        end else begin
          want = expected_q.pop_front();
          if (out_bus.location !== want.location ||
              out_bus.removed_size !== want.removed_size ||
              out_bus.overflow !== want.overflow) begin
            mismatches++;
            $display({"%0t: result mismatch: ",
                      "expected location %0d removed_size 0x%h overflow %0b, ",
                      "got location %0d removed_size 0x%h overflow %0b"},
                     $time, want.location, want.removed_size, want.overflow,
                     out_bus.location, out_bus.removed_size, out_bus.overflow);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: any stretch without a transaction on either side is a hang
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin : watchdog
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus build, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [ADDR_W-1:0] cluster [4];
    logic [CTX_W-1:0]  ctx_pool [3];
    live_range_t       live [$];
    logic [CTX_W-1:0]  ctx;
    logic [CLS_W-1:0]  cls;
    logic [ADDR_W-1:0] base;
    int                first_random;
    int                roll;
    int                idx;
    int                k;
    int                ins_cut;
    int                rem_cut;

    rst_n         = 1'b0;
    in_bus.valid  = 1'b0;
    in_bus.op           = OP_NOP;
    in_bus.context_req  = '0;
    in_bus.region_class = CLS_SHARED;
    in_bus.address      = '0;
    in_bus.length       = '0;
    out_bus.ready = 1'b0;
    for (k = 0; k < MRCT_TABLE_ENTRIES; k++)
      shadow[k] = '0;

    // Directed: class priority, end replace, wrapped and full-width ends,
    // ignored class, unused opcode, context and base mismatches.
    queue_req(OP_LOOKUP, 8'h00, CLS_SHARED, 64'h0, 64'h0);          // empty table
    queue_req(OP_INSERT, 8'h00, CLS_SHARED, 64'h1000, 64'h100);
    queue_req(OP_INSERT, 8'h00, CLS_DEVICE, 64'h1000, 64'h200);     // same base, other class
    queue_req(OP_INSERT, 8'hFF, CLS_HOST, 64'hFFFF_FFFF_FFFF_FF00, 64'h200);  // end wraps
    queue_req(OP_LOOKUP, 8'hFF, CLS_HOST, 64'hFFFF_FFFF_FFFF_FF80, 64'h0);    // wrapped: miss
    queue_req(OP_LOOKUP, 8'h00, CLS_HOST, 64'h1080, 64'h0);         // shared wins
    queue_req(OP_LOOKUP, 8'h00, CLS_SHARED, 64'h1150, 64'h0);       // past shared: device
    queue_req(OP_INSERT, 8'h00, CLS_SHARED, 64'h1000, 64'h300);     // end replaced
    queue_req(OP_LOOKUP, 8'h00, CLS_DEVICE, 64'h1150, 64'h0);       // shared again
    queue_req(OP_INSERT, 8'h00, CLS_BOGUS, 64'h5000, 64'h10);       // ignored
    queue_req(OP_LOOKUP, 8'h00, CLS_SHARED, 64'h5008, 64'h0);
    queue_req(OP_LOOKUP, 8'h01, CLS_SHARED, 64'h1080, 64'h0);       // other context
    queue_req(OP_REMOVE, 8'h00, CLS_HOST, 64'h1000, 64'h0);         // shared goes first
    queue_req(OP_REMOVE, 8'h00, CLS_SHARED, 64'h1000, 64'h0);       // then device
    queue_req(OP_REMOVE, 8'h00, CLS_SHARED, 64'h1000, 64'h0);       // nothing left
    queue_req(OP_REMOVE, 8'hFF, CLS_SHARED, 64'hFFFF_FFFF_FFFF_FF00, 64'h0);
    queue_req(OP_NOP, 8'hFF, CLS_BOGUS, '1, '1);
    queue_req(OP_INSERT, 8'hAA, CLS_HOST, 64'h0, '1);               // end all ones
    queue_req(OP_LOOKUP, 8'hAA, CLS_SHARED, 64'hFFFF_FFFF_FFFF_FFFE, 64'h0);
    queue_req(OP_LOOKUP, 8'hAA, CLS_SHARED, '1, '1);                // at the end: miss
    queue_req(OP_INSERT, 8'h55, CLS_DEVICE, 64'h2000, 64'h0);       // empty range
    queue_req(OP_LOOKUP, 8'h55, CLS_DEVICE, 64'h2000, 64'h0);
    queue_req(OP_REMOVE, 8'h55, CLS_DEVICE, 64'h0, 64'h0);          // base mismatch
    queue_req(OP_REMOVE, 8'hAA, CLS_DEVICE, 64'h0, 64'h0);          // full-width size

    // Random: ranges packed into a few address clusters so they overlap and
    // lookups land on, between and just past them. One cluster sits at the top.
    first_random  = pending.size();
    planned_items = first_random + RANDOM_ITEMS;
    cluster[0] = rand64() & ~64'hF_FFFF;
    cluster[1] = rand64() & ~64'hF_FFFF;
    cluster[2] = 64'h0;
    cluster[3] = 64'hFFFF_FFFF_FFFF_8000;
    for (k = 0; k < 3; k++)
      ctx_pool[k] = CTX_W'($urandom_range(0, 255));

    while (pending.size() < planned_items) begin
      roll    = $urandom_range(0, 99);
      ins_cut = (live.size() > 56) ? 20 : 40;
      rem_cut = (live.size() > 56) ? 75 : 62;
      if (pending.size() == first_random + 300 || pending.size() == first_random + 800) begin
        // Burst of distinct inserts under one context: runs the table into overflow
        ctx = CTX_W'($urandom_range(0, 255));
        for (k = 0; k < 70; k++) begin
          cls  = CLS_W'($urandom_range(0, NUM_CLS - 1));
          base = cluster[0] + 64'h10_0000 + (ADDR_W'(k) << 6);
          queue_req(OP_INSERT, ctx, cls, base, 64'h40);
          live.push_back('{ctx, cls, base});
        end
      end else if (roll < 8) begin
        // Noise: unused opcode, ignored class, stray remove or lookup
        case ($urandom_range(0, 3))
          0: queue_req(OP_NOP, CTX_W'($urandom_range(0, 255)), CLS_W'($urandom_range(0, 3)),
                       rand64(), rand64());
          1: queue_req(OP_INSERT, CTX_W'($urandom_range(0, 255)), CLS_BOGUS, rand64(),
                       pick_length());
          2: queue_req(OP_REMOVE, CTX_W'($urandom_range(0, 255)), CLS_W'($urandom_range(0, 3)),
                       rand64(), rand64());
          default: queue_req(OP_LOOKUP, CTX_W'($urandom_range(0, 255)),
                             CLS_W'($urandom_range(0, 3)), rand64(), rand64());
        endcase
      end else if (roll < ins_cut) begin
        if (live.size() > 0 && $urandom_range(0, 4) == 0) begin
          idx = $urandom_range(0, live.size() - 1);
          queue_req(OP_INSERT, live[idx].ctx, live[idx].cls, live[idx].base, pick_length());
        end else begin
          ctx  = ($urandom_range(0, 9) == 0) ? CTX_W'($urandom_range(0, 255))
                                             : ctx_pool[$urandom_range(0, 2)];
          cls  = CLS_W'($urandom_range(0, NUM_CLS - 1));
          base = cluster[$urandom_range(0, 3)] + (ADDR_W'($urandom_range(0, 255)) << 6);
          queue_req(OP_INSERT, ctx, cls, base, pick_length());
          live.push_back('{ctx, cls, base});
        end
      end else if (roll < rem_cut) begin
        if (live.size() > 0 && $urandom_range(0, 6) != 0) begin
          idx = $urandom_range(0, live.size() - 1);
          queue_req(OP_REMOVE, live[idx].ctx, CLS_W'($urandom_range(0, 3)), live[idx].base,
                    rand64());
          live.delete(idx);
        end else begin
          queue_req(OP_REMOVE, ctx_pool[$urandom_range(0, 2)], CLS_W'($urandom_range(0, 3)),
                    cluster[$urandom_range(0, 3)] + (ADDR_W'($urandom_range(0, 255)) << 6),
                    rand64());
        end
      end else begin
        if (live.size() > 0 && $urandom_range(0, 4) != 0) begin
          idx = $urandom_range(0, live.size() - 1);
          queue_req(OP_LOOKUP, live[idx].ctx, CLS_W'($urandom_range(0, 3)),
                    live[idx].base + ADDR_W'($urandom_range(0, 'h2100)) - 64'h80, rand64());
        end else begin
          queue_req(OP_LOOKUP, ctx_pool[$urandom_range(0, 2)], CLS_W'($urandom_range(0, 3)),
                    cluster[$urandom_range(0, 3)] + ADDR_W'($urandom_range(0, 'h5000)),
                    rand64());
        end
      end
    end
    planned_items = pending.size();

    // Sender waits for an empty pipe before the random part and once in the middle
    pending[first_random].wait_drain       = 1'b1;
    pending[first_random + 600].wait_drain = 1'b1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Everything sent and every result back, then let the block sit a while
    while (pending.size() > 0 || in_bus.valid || expected_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* sim.f */
sv/mrct_pkg.sv
sv/mrct_in_if.sv
sv/mrct_out_if.sv
sv/mrct_datapath.sv
sv/mrct_ctrl.sv
sv/memory_region_classifier_table_unit.sv
bench/memory_region_classifier_table_unit_tb.sv
